// ===== src/mcr_pkg.sv =====
package mcr_pkg;

  localparam int COORD_W = 10;
  localparam int RADIUS_W = 9;
  localparam int TERM_W = 16;
  localparam int PIX_W = 12;
  localparam int ADDR_W = 22;
  localparam int COLOR_W = 8;
  localparam int CFG_INDEX_W = 2;
  localparam int QUEUE_DEPTH = 4;

  localparam logic MODE_START = 1'b0;

  localparam logic [CFG_INDEX_W-1:0] CFG_RED = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_GREEN = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_BLUE = 2'd2;

  localparam logic [2:0] LAST_OCTANT = 3'd7;

  // one step of the circle: offsets, center, and whether it is the last step
  typedef struct packed {
    logic [COORD_W-1:0] off_a;
    logic [COORD_W-1:0] off_b;
    logic [COORD_W-1:0] center_row;
    logic [COORD_W-1:0] center_col;
    logic               done;
  } step_t;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } color_t;

endpackage

// ===== src/mcr_front.sv =====
module mcr_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  logic [31:0]    in_tdata,
  input  logic           in_tuser,
  input  logic           q_full,
  output logic           q_push,
  output mcr_pkg::step_t q_step
);

  logic [mcr_pkg::COORD_W-1:0] off_a_r, off_b_r, held_row_r, held_col_r;
  logic [mcr_pkg::COORD_W-1:0] off_a_nxt, off_b_nxt, held_row_nxt, held_col_nxt;
  logic [mcr_pkg::TERM_W-1:0]  term_r, term_nxt;
  logic                        active_r, active_nxt;

  logic [mcr_pkg::COORD_W-1:0] a_cur, b_cur, row_cur, col_cur;
  logic [mcr_pkg::TERM_W-1:0]  term_cur, term_step, term_calc;
  logic                        act_cur, term_pos, go, done, accept;
  logic [mcr_pkg::COORD_W:0]   na, nb;

  assign in_tready = !q_full;
  assign accept = in_tvalid && in_tready;

  always_comb begin
    a_cur = off_a_r;
    b_cur = off_b_r;
    term_cur = term_r;
    act_cur = active_r;
    row_cur = held_row_r;
    col_cur = held_col_r;
    if (in_tuser == mcr_pkg::MODE_START) begin
      row_cur = in_tdata[9:0];
      col_cur = in_tdata[19:10];
      a_cur = '0;
      b_cur = {1'b0, in_tdata[28:20]};
      // 5 - 4r
      term_cur = 16'd5 - {5'b0, in_tdata[28:20], 2'b00};
      act_cur = 1'b1;
    end
  end

  always_comb begin
    term_pos = !term_cur[15] && (term_cur != '0);
    nb = {1'b0, b_cur} - {10'b0, term_pos};
    term_step = term_cur - (term_pos ? {{2{nb[10]}}, nb, 3'b000} : 16'd0);
    na = {1'b0, a_cur} + 11'd1;
    term_calc = term_step + {2'b00, na, 3'b000} + 16'd4;
    done = $signed({1'b0, na}) > $signed({nb[10], nb});
    go = act_cur && (a_cur <= b_cur);

    off_a_nxt = go ? na[9:0] : a_cur;
    off_b_nxt = go ? (nb[10] ? '0 : nb[9:0]) : b_cur;
    term_nxt = go ? term_calc : term_cur;
    active_nxt = go && !done;
    held_row_nxt = row_cur;
    held_col_nxt = col_cur;
  end

  assign q_push = accept && go;
  assign q_step = '{off_a: a_cur, off_b: b_cur, center_row: row_cur,
                    center_col: col_cur, done: done};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_a_r <= '0;
      off_b_r <= '0;
      term_r <= '0;
      active_r <= 1'b0;
      held_row_r <= '0;
      held_col_r <= '0;
    end else if (accept) begin
      off_a_r <= off_a_nxt;
      off_b_r <= off_b_nxt;
      term_r <= term_nxt;
      active_r <= active_nxt;
      held_row_r <= held_row_nxt;
      held_col_r <= held_col_nxt;
    end
  end

endmodule

// ===== src/mcr_queue.sv =====
module mcr_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  mcr_pkg::step_t push_step,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output mcr_pkg::step_t head_step
);

  localparam int PTR_W = $clog2(mcr_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(mcr_pkg::QUEUE_DEPTH + 1);

  mcr_pkg::step_t   entry_r [mcr_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full = (count_r == CNT_W'(mcr_pkg::QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_step = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(mcr_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(mcr_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ===== src/mcr_back.sv =====
module mcr_back #(
  parameter int FRAME_WIDTH = 1024,
  parameter int FRAME_HEIGHT = 1024
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            head_valid,
  input  mcr_pkg::step_t  head_step,
  output logic            pop,
  input  mcr_pkg::color_t color,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [71:0]     out_tdata,
  output logic            out_tuser,
  output logic            out_tlast
);

  localparam logic [12:0] FW_C = 13'(FRAME_WIDTH);
  localparam logic [12:0] FH_C = 13'(FRAME_HEIGHT);

  logic [2:0]  octant_r;
  logic        s1_valid_r;
  logic [12:0] s1_row_r, s1_col_r;
  logic        s1_last_r;

  logic        out_valid_r, out_off_r, out_last_r;
  logic [mcr_pkg::PIX_W-1:0]  out_row_r, out_col_r;
  logic [mcr_pkg::ADDR_W-1:0] out_addr_r;
  mcr_pkg::color_t            out_color_r;

  logic        out_ready, s1_ready, load;
  logic [mcr_pkg::COORD_W-1:0] dr, dc;
  logic [12:0] row_calc, col_calc;
  logic        off_calc;
  logic [24:0] lin;

  assign out_ready = !out_valid_r || out_tready;
  assign s1_ready = !s1_valid_r || out_ready;
  assign load = head_valid && s1_ready;
  assign pop = load && (octant_r == mcr_pkg::LAST_OCTANT);

  // bit 0 swaps the offsets, bit 1 mirrors the row, bit 2 mirrors the column
  always_comb begin
    dr = octant_r[0] ? head_step.off_b : head_step.off_a;
    dc = octant_r[0] ? head_step.off_a : head_step.off_b;
    row_calc = octant_r[1] ? {3'b0, head_step.center_row} - {3'b0, dr}
                           : {3'b0, head_step.center_row} + {3'b0, dr};
    col_calc = octant_r[2] ? {3'b0, head_step.center_col} - {3'b0, dc}
                           : {3'b0, head_step.center_col} + {3'b0, dc};
  end

  always_comb begin
    off_calc = s1_row_r[12] || ({1'b0, s1_row_r[11:0]} >= FH_C) ||
               s1_col_r[12] || ({1'b0, s1_col_r[11:0]} >= FW_C);
    lin = 25'(s1_row_r[11:0]) * 25'(FW_C) + 25'(s1_col_r[11:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      octant_r <= '0;
      s1_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        octant_r <= octant_r + 1'b1;
      end
      if (s1_ready) begin
        s1_valid_r <= head_valid;
      end
      if (out_ready) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_row_r <= row_calc;
      s1_col_r <= col_calc;
      s1_last_r <= head_step.done && (octant_r == mcr_pkg::LAST_OCTANT);
    end
    if (out_ready && s1_valid_r) begin
      out_row_r <= s1_row_r[11:0];
      out_col_r <= s1_col_r[11:0];
      out_off_r <= off_calc;
      out_addr_r <= off_calc ? '0 : {lin[19:0], 2'b00};
      out_last_r <= s1_last_r;
      out_color_r <= color;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser = out_off_r;
  assign out_tlast = out_last_r;
  assign out_tdata = {2'b00, out_color_r.blue, out_color_r.green, out_color_r.red,
                      out_addr_r, out_col_r, out_row_r};

endmodule

// ===== src/midpoint_circle_rasterizer_top.sv =====
// midpoint circle rasterizer
// input stream: each request is one circle step. in_tuser = 0 starts a circle
// from the center and radius in in_tdata, in_tuser = 1 advances the current one.
// a step that runs yields eight mirrored pixels on the output stream; advance
// requests with no circle in progress yield nothing.
// output stream: one pixel per request with row, column, frame byte address and
// color in out_tdata, out_tuser set for off-screen pixels (address zero) and
// out_tlast on the final pixel of the circle.
// color registers are to be written by the user through cfg_we / cfg_index /
// cfg_data only while idle; the block itself does not enforce it.
// a step is held in the step queue, its pixels pass the s1 and output registers.
// throughput: one pixel per cycle while out_tready is high, set by the single pixel
// output port; the front takes a request per cycle while the 4-entry queue has room.
// reset clears the circle state, the queue, the pipeline and the colors.
// when the receiver stalls, the pixel pipeline holds, the queue fills and
// in_tready drops once four steps are waiting.
module midpoint_circle_rasterizer_top #(
  parameter int FRAME_WIDTH = 1024,
  parameter int FRAME_HEIGHT = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,  // center_row[9:0], center_col[19:10], radius[28:20]
  input  logic        in_tuser,  // mode
  output logic        out_tvalid,
  input  logic        out_tready,
  // pixel_row[11:0], pixel_col[23:12], byte_address[45:24], red_out[53:46],
  // green_out[61:54], blue_out[69:62]
  output logic [71:0] out_tdata,
  output logic        out_tuser, // off_screen
  output logic        out_tlast, // final_pixel
  input  logic        cfg_we,
  input  logic [mcr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [mcr_pkg::COLOR_W-1:0]     cfg_data
);

  mcr_pkg::color_t color_r;
  mcr_pkg::step_t  push_step, head_step;
  logic            q_full, q_push, q_pop, head_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mcr_pkg::CFG_RED:   color_r.red <= cfg_data;
        mcr_pkg::CFG_GREEN: color_r.green <= cfg_data;
        mcr_pkg::CFG_BLUE:  color_r.blue <= cfg_data;
        default:            color_r <= color_r;
      endcase
    end
  end

  mcr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_step    (push_step)
  );

  mcr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_step  (push_step),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_step  (head_step)
  );

  mcr_back #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_step  (head_step),
    .pop        (q_pop),
    .color      (color_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== test/midpoint_circle_rasterizer_top_tb.sv =====
`timescale 1ns / 100ps

module midpoint_circle_rasterizer_top_tb;

  localparam int FRAME_W = 1024;
  localparam int FRAME_H = 1024;
  localparam logic MODE_ADVANCE = 1'b1;
  localparam int HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 16;

  // how the expected pixels of a request are obtained
  typedef enum logic [1:0] {
    EXP_PREDICT,
    EXP_NOTHING,
    EXP_CENTER
  } expect_kind_t;

  typedef struct packed {
    logic [mcr_pkg::PIX_W-1:0]   row;
    logic [mcr_pkg::PIX_W-1:0]   col;
    logic [mcr_pkg::ADDR_W-1:0]  addr;
    logic                        off;
    logic [mcr_pkg::COLOR_W-1:0] red;
    logic [mcr_pkg::COLOR_W-1:0] green;
    logic [mcr_pkg::COLOR_W-1:0] blue;
    logic                        last;
  } pixel_t;

  typedef struct {
    logic         mode;
    int           row;
    int           col;
    int           rad;
    expect_kind_t kind;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;
  logic        cfg_we;
  logic [mcr_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [mcr_pkg::COLOR_W-1:0]     cfg_data;

  // stimulus side state
  expect_kind_t in_kind;
  logic         calm;
  int           hold_seq = 0;
  int           hold_seen = 0;
  int           hold_left = 0;
  int           quiet_cycles = 0;
  int           mismatches = 0;
  int           drawn_steps = 0;

  // circle tracker and color shadow
  logic [mcr_pkg::COORD_W-1:0] arc_a, arc_b, arc_row, arc_col;
  logic signed [mcr_pkg::TERM_W-1:0] arc_term;
  logic                        arc_live;
  logic [mcr_pkg::COLOR_W-1:0] paint_red, paint_green, paint_blue;

  pixel_t pending_pixels[$];
  pixel_t oldest;

  stim_row_t directed_rows [22] = '{
    '{MODE_ADVANCE, 0, 0, 0, EXP_NOTHING},            // nothing in progress yet
    '{mcr_pkg::MODE_START, 512, 512, 0, EXP_CENTER},  // zero radius
    '{MODE_ADVANCE, 1023, 1023, 511, EXP_NOTHING},
    '{mcr_pkg::MODE_START, 0, 0, 0, EXP_CENTER},
    '{mcr_pkg::MODE_START, 1023, 1023, 0, EXP_CENTER},
    '{mcr_pkg::MODE_START, 0, 1023, 0, EXP_CENTER},
    '{mcr_pkg::MODE_START, 0, 0, 511, EXP_PREDICT},   // mostly off screen, negative coords
    '{MODE_ADVANCE, 0, 0, 0, EXP_PREDICT},
    '{MODE_ADVANCE, 0, 0, 0, EXP_PREDICT},
    '{mcr_pkg::MODE_START, 1023, 1023, 511, EXP_PREDICT},  // largest coordinates
    '{MODE_ADVANCE, 1023, 1023, 511, EXP_PREDICT},
    '{mcr_pkg::MODE_START, 100, 200, 3, EXP_PREDICT},
    '{MODE_ADVANCE, 0, 0, 0, EXP_PREDICT},
    '{MODE_ADVANCE, 0, 0, 0, EXP_PREDICT},
    '{MODE_ADVANCE, 0, 0, 0, EXP_NOTHING},            // radius 3 ends after three steps
    '{mcr_pkg::MODE_START, 5, 1020, 10, EXP_PREDICT},
    '{MODE_ADVANCE, 0, 0, 0, EXP_PREDICT},
    '{mcr_pkg::MODE_START, 300, 400, 1, EXP_PREDICT}, // restart drops the old circle
    '{MODE_ADVANCE, 300, 400, 1, EXP_NOTHING},
    '{mcr_pkg::MODE_START, 512, 0, 2, EXP_PREDICT},
    '{MODE_ADVANCE, 1023, 1023, 511, EXP_PREDICT},
    '{MODE_ADVANCE, 1023, 1023, 511, EXP_PREDICT}
  };

  midpoint_circle_rasterizer_top #(
    .FRAME_WIDTH (FRAME_W),
    .FRAME_HEIGHT(FRAME_H)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void queue_pixel(int row, int col, logic last);
    pixel_t px;
    px.off = (row < 0 || row >= FRAME_H || col < 0 || col >= FRAME_W);
    px.row = mcr_pkg::PIX_W'(row);
    px.col = mcr_pkg::PIX_W'(col);
    px.addr = px.off ? '0 : mcr_pkg::ADDR_W'((row * FRAME_W + col) * 4);
    px.red = paint_red;
    px.green = paint_green;
    px.blue = paint_blue;
    px.last = last;
    pending_pixels.push_back(px);
  endfunction

  // one request: load or step the circle, queue its eight mirrored pixels
  function automatic void advance_circle(logic mode, logic [mcr_pkg::COORD_W-1:0] crow,
                                         logic [mcr_pkg::COORD_W-1:0] ccol,
                                         logic [mcr_pkg::RADIUS_W-1:0] rad, bit record);
    int  a, b, m, na, nb, nm, cr, cc;
    bit  done;
    if (mode == mcr_pkg::MODE_START) begin
      arc_row = crow;
      arc_col = ccol;
      arc_a = '0;
      arc_b = mcr_pkg::COORD_W'(rad);
      arc_term = mcr_pkg::TERM_W'(5 - 4 * int'(rad));
      arc_live = 1'b1;
    end
    if (!arc_live) return;
    a = int'(arc_a);
    b = int'(arc_b);
    m = int'(arc_term);
    cr = int'(arc_row);
    cc = int'(arc_col);
    if (a > b) begin
      arc_live = 1'b0;
      return;
    end
    nb = b;
    nm = m;
    if (nm > 0) begin
      nb = nb - 1;
      nm = nm - 8 * nb;
    end
    na = a + 1;
    nm = nm + 8 * na + 4;
    done = na > nb;
    arc_a = mcr_pkg::COORD_W'(na);
    arc_b = (nb < 0) ? '0 : mcr_pkg::COORD_W'(nb);
    arc_term = mcr_pkg::TERM_W'(nm);
    arc_live = !done;
    drawn_steps++;
    if (record) begin
      queue_pixel(cr + a, cc + b, 1'b0);
      queue_pixel(cr + b, cc + a, 1'b0);
      queue_pixel(cr - a, cc + b, 1'b0);
      queue_pixel(cr - b, cc + a, 1'b0);
      queue_pixel(cr + a, cc - b, 1'b0);
      queue_pixel(cr + b, cc - a, 1'b0);
      queue_pixel(cr - a, cc - b, 1'b0);
      queue_pixel(cr - b, cc - a, done);
    end
  endfunction

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endfunction

  // output checking, then prediction for the request taken at this edge
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_pixels.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected pixel, expected none, got %0h user %0b last %0b",
                 $time, out_tdata, out_tuser, out_tlast);
      end else begin
        oldest = pending_pixels.pop_front();
        compare_field("pixel_row", 32'(oldest.row), 32'(out_tdata[11:0]));
        compare_field("pixel_col", 32'(oldest.col), 32'(out_tdata[23:12]));
        compare_field("byte_address", 32'(oldest.addr), 32'(out_tdata[45:24]));
        compare_field("off_screen", 32'(oldest.off), 32'(out_tuser));
        compare_field("red_out", 32'(oldest.red), 32'(out_tdata[53:46]));
        compare_field("green_out", 32'(oldest.green), 32'(out_tdata[61:54]));
        compare_field("blue_out", 32'(oldest.blue), 32'(out_tdata[69:62]));
        compare_field("final_pixel", 32'(oldest.last), 32'(out_tlast));
      end
    end
    if (rst_n && in_tvalid && in_tready) begin
      advance_circle(in_tuser, in_tdata[9:0], in_tdata[19:10], in_tdata[28:20],
                     in_kind == EXP_PREDICT);
      if (in_kind == EXP_CENTER) begin
        // zero radius: all eight pixels sit on the center
        for (int k = 0; k < 8; k++) begin
          pending_pixels.push_back('{row: {2'b00, in_tdata[9:0]},
                                     col: {2'b00, in_tdata[19:10]},
                                     addr: {in_tdata[9:0], in_tdata[19:10], 2'b00},
                                     off: 1'b0, red: paint_red, green: paint_green,
                                     blue: paint_blue, last: (k == 7)});
        end
      end
    end
  end

  // pixel receiver, with a long hold-off on request from the stimulus
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_left <= 0;
      hold_seen <= hold_seq;
    end else if (hold_seen != hold_seq) begin
      hold_seen <= hold_seq;
      hold_left <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= calm || ($urandom_range(99) >= 27);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_item(logic mode, logic [mcr_pkg::COORD_W-1:0] crow,
                           logic [mcr_pkg::COORD_W-1:0] ccol,
                           logic [mcr_pkg::RADIUS_W-1:0] rad, expect_kind_t kind);
    while (!calm && $urandom_range(99) < 27) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= mode;
    in_tdata <= {3'b000, rad, ccol, crow};
    in_kind <= kind;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic wait_drained(int settle);
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending_pixels.size() != 0);
    repeat (settle + 1) @(posedge clk);
  endtask

  task automatic write_reg(logic [mcr_pkg::CFG_INDEX_W-1:0] idx,
                           logic [mcr_pkg::COLOR_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    case (idx)
      mcr_pkg::CFG_RED:   paint_red = value;
      mcr_pkg::CFG_GREEN: paint_green = value;
      mcr_pkg::CFG_BLUE:  paint_blue = value;
      default:   ;
    endcase
  endtask

  task automatic set_colors(logic [mcr_pkg::COLOR_W-1:0] r, logic [mcr_pkg::COLOR_W-1:0] g,
                            logic [mcr_pkg::COLOR_W-1:0] b);
    write_reg(mcr_pkg::CFG_RED, r);
    write_reg(mcr_pkg::CFG_GREEN, g);
    write_reg(mcr_pkg::CFG_BLUE, b);
    cfg_we <= 1'b0;
  endtask

  // mostly whole circles with random center and radius, some cut short,
  // some stray advances and the odd full drain
  task automatic random_circle();
    int pick;
    int rad;
    int runs;
    pick = $urandom_range(99);
    if (pick < 5) begin
      wait_drained(0);
      return;
    end
    if (pick < 15) begin
      send_item(MODE_ADVANCE, mcr_pkg::COORD_W'($urandom), mcr_pkg::COORD_W'($urandom),
                mcr_pkg::RADIUS_W'($urandom), EXP_PREDICT);
      return;
    end
    pick = $urandom_range(99);
    if (pick < 80) rad = $urandom_range(24);
    else if (pick < 95) rad = $urandom_range(60);
    else rad = $urandom_range(511, 256);
    send_item(mcr_pkg::MODE_START, mcr_pkg::COORD_W'($urandom), mcr_pkg::COORD_W'($urandom),
              mcr_pkg::RADIUS_W'(rad), EXP_PREDICT);
    if (rad > 60) runs = $urandom_range(6);
    else if ($urandom_range(99) < 75) runs = rad * 3 / 4 + 2;
    else runs = $urandom_range(rad);
    repeat (runs) begin
      send_item(MODE_ADVANCE, mcr_pkg::COORD_W'($urandom), mcr_pkg::COORD_W'($urandom),
                mcr_pkg::RADIUS_W'($urandom), EXP_PREDICT);
    end
  endtask

  task automatic random_phase(int stop_at);
    while (drawn_steps < stop_at) random_circle();
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tuser = 1'b0;
    in_tdata = '0;
    in_kind = EXP_PREDICT;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    calm = 1'b0;
    arc_a = '0;
    arc_b = '0;
    arc_term = '0;
    arc_live = 1'b0;
    arc_row = '0;
    arc_col = '0;
    paint_red = '0;
    paint_green = '0;
    paint_blue = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // colors still at their reset value here
    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].mode, mcr_pkg::COORD_W'(directed_rows[i].row),
                mcr_pkg::COORD_W'(directed_rows[i].col),
                mcr_pkg::RADIUS_W'(directed_rows[i].rad), directed_rows[i].kind);
    end

    wait_drained(SETTLE_CYCLES);
    set_colors(8'hFF, 8'hFF, 8'hFF);
    random_phase(55);

    // receiver stalls long enough to back up the step queue
    wait_drained(SETTLE_CYCLES);
    set_colors(mcr_pkg::COLOR_W'($urandom), mcr_pkg::COLOR_W'($urandom),
               mcr_pkg::COLOR_W'($urandom));
    hold_seq <= hold_seq + 1;
    random_phase(90);

    wait_drained(SETTLE_CYCLES);
    set_colors(8'h00, 8'hFF, 8'h00);
    calm <= 1'b1;
    random_phase(110);
    calm <= 1'b0;
    random_phase(128);

    wait_drained(SETTLE_CYCLES);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/mcr_pkg.sv
src/mcr_front.sv
src/mcr_queue.sv
src/mcr_back.sv
src/midpoint_circle_rasterizer_top.sv
test/midpoint_circle_rasterizer_top_tb.sv
